>>> sv/rce_pkg.sv
// Shared types and constants for the Roberts cross edge threshold block.
// No dependencies; every other file imports this package.
package rce_pkg;

   localparam int PIXEL_W  = 8;
   localparam int COORD_W  = 10;
   localparam int MAG_W    = 9;
   localparam int SIZE_W   = 11;
   localparam int CSR_IDX_W = 2;

   localparam int QUEUE_DEPTH = 4;

   // result kinds, one mask bit each, in emit order
   localparam int KIND_CROSS  = 0;
   localparam int KIND_RIGHT  = 1;
   localparam int KIND_BOTTOM = 2;
   localparam int KIND_CORNER = 3;
   localparam int KIND_N      = 4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd2;

   localparam logic [SIZE_W-1:0] WIDTH_RESET     = 11'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET    = 11'd480;
   localparam logic [MAG_W-1:0]  THRESHOLD_RESET = 9'd64;

   // one classified pixel, carried from front to back
   typedef struct packed {
      logic [KIND_N-1:0]  kinds;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [MAG_W-1:0]   mag_cross;
      logic [MAG_W-1:0]   mag_right;
      logic [MAG_W-1:0]   mag_bottom;
      logic [PIXEL_W-1:0] pixel;
   } rce_task_type;

endpackage

>>> sv/rce_if.sv
// Stream interfaces of the Roberts cross block: pixel input, result output
// and configuration write channel. Depends on rce_pkg.
interface rce_req_if;
   import rce_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   modport source(output valid, output pixel, input ready);
   modport sink(input valid, input pixel, output ready);
endinterface

interface rce_rsp_if;
   import rce_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] out_col;
   logic [COORD_W-1:0] out_row;
   logic [MAG_W-1:0]   magnitude;
   logic               edge_bit;
   logic               frame_last;
   modport source(output valid, output out_col, output out_row, output magnitude,
                  output edge_bit, output frame_last, input ready);
   modport sink(input valid, input out_col, input out_row, input magnitude,
                input edge_bit, input frame_last, output ready);
endinterface

interface rce_csr_if;
   import rce_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [SIZE_W-1:0]    data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

>>> sv/roberts_cross_edge_threshold.sv
// Roberts cross edge detector with threshold. A pixel's first result passes
// stage-1, queue, task and output registers. Throughput while rsp.ready holds:
// one pixel per clock while a pixel yields at most one result; the output
// register emits one result per clock, so bottom-row pixels, later rows' last
// pixels (two results each) and the frame's last pixel (four) make bursts the
// 4-deep task queue absorbs. Reset clears counters, pipeline and queue, loads
// 640/480/64; the line store is not cleared (row 0 fills it before any read).
module roberts_cross_edge_threshold #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   rce_req_if.sink     req,
   rce_rsp_if.source   rsp,
   rce_csr_if.sink     csr
);
   import rce_pkg::*;

   logic               fq_valid, fq_ready, qb_valid, qb_ready;
   rce_task_type       fq_word, qb_word;
   logic [MAG_W-1:0]   threshold;

   rce_front #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req(req),
      .csr(csr),
      .task_valid(fq_valid),
      .task_ready(fq_ready),
      .task_word(fq_word),
      .threshold(threshold)
   );

   rce_queue u_queue (
      .clock(clock),
      .reset(reset),
      .in_valid(fq_valid),
      .in_ready(fq_ready),
      .in_word(fq_word),
      .out_valid(qb_valid),
      .out_ready(qb_ready),
      .out_word(qb_word)
   );

   rce_back u_back (
      .clock(clock),
      .reset(reset),
      .task_valid(qb_valid),
      .task_ready(qb_ready),
      .task_word(qb_word),
      .threshold(threshold),
      .rsp(rsp)
   );

`ifndef SYNTHESIS
   a_front_holds: assert property (@(posedge clock) disable iff (reset)
      (fq_valid && !fq_ready) |-> !req.ready)
      else $error("pixel taken while front stage is blocked");

   a_corner_mag: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.frame_last) |-> (rsp.magnitude <= 9'd255))
      else $error("corner result carries more than one pixel value");

   a_edge_bit: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.edge_bit) |-> (rsp.magnitude > threshold))
      else $error("edge bit set at or below threshold");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("result valid right after reset");
`endif

endmodule

>>> sv/rce_front.sv
// Front part: configuration registers, raster counters, line store and
// classification of each pixel into a task word. Depends on rce_pkg, rce_if.
module rce_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   rce_req_if.sink                     req,
   rce_csr_if.sink                     csr,
   output logic                        task_valid,
   input  logic                        task_ready,
   output rce_pkg::rce_task_type       task_word,
   output logic [rce_pkg::MAG_W-1:0]   threshold
);
   import rce_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [SIZE_W-1:0]  width_ff, height_ff;
   logic [MAG_W-1:0]   thr_ff;
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [31:0]        w_clamp, h_clamp;
   logic [CW-1:0]      last_col;
   logic [RW-1:0]      last_row;

   logic [PIXEL_W-1:0] line_mem [MAX_WIDTH];
   logic [PIXEL_W-1:0] up_ff;

   logic               s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic [COORD_W-1:0] s1_col_ff, s1_row_ff;
   logic [KIND_N-1:0]  s1_kinds_ff, kinds;
   logic [PIXEL_W-1:0] left_ff, upleft_ff;

   logic accept, push, csr_we, size_we;

   function automatic logic [MAG_W-1:0] abs_diff(input logic [PIXEL_W-1:0] a,
                                                 input logic [PIXEL_W-1:0] b);
      logic [PIXEL_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return MAG_W'(d);
   endfunction

   assign csr.ready = 1'b1;
   assign csr_we    = csr.valid && csr.ready;
   assign size_we   = csr_we && (csr.index inside {CSR_WIDTH, CSR_HEIGHT});

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         thr_ff    <= THRESHOLD_RESET;
      end else if (csr_we) begin
         case (csr.index)
            CSR_WIDTH:     width_ff  <= csr.data;
            CSR_HEIGHT:    height_ff <= csr.data;
            CSR_THRESHOLD: thr_ff    <= csr.data[MAG_W-1:0];
            default:       ;
         endcase
      end
   end

   assign threshold = thr_ff;

   // limit the frame size to 2..MAX
   always_comb begin
      if ({21'd0, width_ff} < 32'd2)                 w_clamp = 32'd2;
      else if ({21'd0, width_ff} > 32'(MAX_WIDTH))   w_clamp = 32'(MAX_WIDTH);
      else                                           w_clamp = {21'd0, width_ff};
      if ({21'd0, height_ff} < 32'd2)                h_clamp = 32'd2;
      else if ({21'd0, height_ff} > 32'(MAX_HEIGHT)) h_clamp = 32'(MAX_HEIGHT);
      else                                           h_clamp = {21'd0, height_ff};
   end

   assign last_col = CW'(w_clamp - 32'd1);
   assign last_row = RW'(h_clamp - 32'd1);

   assign push      = s1_valid_ff && task_ready;
   assign req.ready = !s1_valid_ff || push;
   assign accept    = req.valid && req.ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (size_we) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == last_col) begin
            col_in = '0;
            row_in = (row_ff == last_row) ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_comb begin
      kinds = '0;
      kinds[KIND_CROSS]  = (row_ff != '0) && (col_ff != '0);
      kinds[KIND_RIGHT]  = (row_ff != '0) && (col_ff == last_col);
      kinds[KIND_BOTTOM] = (row_ff == last_row) && (col_ff != '0);
      kinds[KIND_CORNER] = (row_ff == last_row) && (col_ff == last_col);
   end

   assign s1_valid_in = accept ? 1'b1 : (push ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         left_ff     <= '0;
         upleft_ff   <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         if (push) begin
            upleft_ff <= up_ff;
            left_ff   <= s1_pixel_ff;
         end
      end
   end

   // read the row above, then overwrite it with the current pixel
   always_ff @(posedge clock) begin
      if (accept) begin
         up_ff            <= line_mem[col_ff];
         line_mem[col_ff] <= req.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req.pixel;
         s1_col_ff   <= COORD_W'(col_ff);
         s1_row_ff   <= COORD_W'(row_ff);
         s1_kinds_ff <= kinds;
      end
   end

   assign task_valid = s1_valid_ff;

   always_comb begin
      task_word.kinds      = s1_kinds_ff;
      task_word.col        = s1_col_ff;
      task_word.row        = s1_row_ff;
      task_word.mag_cross  = abs_diff(upleft_ff, s1_pixel_ff) + abs_diff(up_ff, left_ff);
      task_word.mag_right  = MAG_W'(up_ff) + MAG_W'(s1_pixel_ff);
      task_word.mag_bottom = MAG_W'(left_ff) + MAG_W'(s1_pixel_ff);
      task_word.pixel      = s1_pixel_ff;
   end

endmodule

>>> sv/rce_queue.sv
// Short task queue between front and back of the Roberts cross block.
// Depends on rce_pkg.
module rce_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rce_pkg::rce_task_type in_word,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rce_pkg::rce_task_type out_word
);
   import rce_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   rce_task_type         slots [QUEUE_DEPTH];
   logic [PW-1:0]        wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]          count_ff, count_in;
   logic                 do_push, do_pop;

   assign in_ready  = (count_ff != PW'(0) + (PW+1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_word  = slots[rd_ff];
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_valid && out_ready;

   always_comb begin
      wr_in    = do_push ? wr_ff + PW'(1) : wr_ff;
      rd_in    = do_pop  ? rd_ff + PW'(1) : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop)      count_in = count_ff + (PW+1)'(1);
      else if (do_pop && !do_push) count_in = count_ff - (PW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slots[wr_ff] <= in_word;
   end

endmodule

>>> sv/rce_back.sv
// Back part: expands each task word into its results, one per cycle into the
// output register while it is free to take one. Depends on rce_pkg, rce_if.
module rce_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      task_valid,
   output logic                      task_ready,
   input  rce_pkg::rce_task_type     task_word,
   input  logic [rce_pkg::MAG_W-1:0] threshold,
   rce_rsp_if.source                 rsp
);
   import rce_pkg::*;

   rce_task_type       t_ff;
   logic               t_valid_ff, t_valid_in;
   logic [KIND_N-1:0]  t_kinds_ff, t_kinds_in, pick, kinds_next;
   logic               out_free, emit, t_done;

   logic               o_valid_ff, o_valid_in;
   logic [COORD_W-1:0] o_col_ff, o_row_ff, r_col, r_row;
   logic [MAG_W-1:0]   o_mag_ff, r_mag;
   logic               o_edge_ff, o_last_ff;

   // lowest pending kind goes first
   always_comb begin
      pick = '0;
      if (t_kinds_ff[KIND_CROSS])       pick[KIND_CROSS]  = 1'b1;
      else if (t_kinds_ff[KIND_RIGHT])  pick[KIND_RIGHT]  = 1'b1;
      else if (t_kinds_ff[KIND_BOTTOM]) pick[KIND_BOTTOM] = 1'b1;
      else if (t_kinds_ff[KIND_CORNER]) pick[KIND_CORNER] = 1'b1;
   end

   assign out_free   = !o_valid_ff || rsp.ready;
   assign emit       = t_valid_ff && (t_kinds_ff != '0) && out_free;
   assign kinds_next = emit ? (t_kinds_ff & ~pick) : t_kinds_ff;
   assign t_done     = t_valid_ff && (kinds_next == '0);
   assign task_ready = !t_valid_ff || t_done;

   always_comb begin
      t_valid_in = t_valid_ff;
      t_kinds_in = kinds_next;
      if (task_valid && task_ready) begin
         t_valid_in = 1'b1;
         t_kinds_in = task_word.kinds;
      end else if (t_done) begin
         t_valid_in = 1'b0;
      end
   end

   always_comb begin
      r_col = (pick[KIND_CROSS] || pick[KIND_BOTTOM]) ? t_ff.col - COORD_W'(1) : t_ff.col;
      r_row = (pick[KIND_CROSS] || pick[KIND_RIGHT])  ? t_ff.row - COORD_W'(1) : t_ff.row;
      if (pick[KIND_CROSS])       r_mag = t_ff.mag_cross;
      else if (pick[KIND_RIGHT])  r_mag = t_ff.mag_right;
      else if (pick[KIND_BOTTOM]) r_mag = t_ff.mag_bottom;
      else                        r_mag = MAG_W'(t_ff.pixel);
   end

   assign o_valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : o_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
         t_kinds_ff <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         t_valid_ff <= t_valid_in;
         t_kinds_ff <= t_kinds_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (task_valid && task_ready) t_ff <= task_word;
      if (emit) begin
         o_col_ff  <= r_col;
         o_row_ff  <= r_row;
         o_mag_ff  <= r_mag;
         o_edge_ff <= (r_mag > threshold);
         o_last_ff <= pick[KIND_CORNER];
      end
   end

   assign rsp.valid      = o_valid_ff;
   assign rsp.out_col    = o_col_ff;
   assign rsp.out_row    = o_row_ff;
   assign rsp.magnitude  = o_mag_ff;
   assign rsp.edge_bit   = o_edge_ff;
   assign rsp.frame_last = o_last_ff;

endmodule

>>> tb/tb_roberts_cross_edge_threshold.sv
// Self-checking bench for roberts_cross_edge_threshold: streams pixel frames of
// many sizes and thresholds and checks every result word against a local model.
// Depends on rce_pkg, the rce_*_if interfaces and the block itself.
module tb_roberts_cross_edge_threshold;
   timeunit 1ns;
   timeprecision 1ps;
   import rce_pkg::*;

   localparam int MAX_SIDE      = 1024;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 80;
   localparam int IDLE_PCT      = 12;
   localparam int RANDOM_ITEMS  = 240;
   localparam int PHASE_CAP     = 30;
   localparam int PRINT_CAP     = 100;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [MAG_W-1:0]   mag;
      logic               edge_bit;
      logic               last;
   } edge_word_type;

   class edge_checker;
      logic [SIZE_W-1:0]  width_reg;
      logic [SIZE_W-1:0]  height_reg;
      logic [MAG_W-1:0]   thresh_reg;
      logic [PIXEL_W-1:0] line_mem [MAX_SIDE];
      logic [PIXEL_W-1:0] left_pix;
      logic [PIXEL_W-1:0] upleft_pix;
      int unsigned        col_cnt;
      int unsigned        row_cnt;
      edge_word_type      due_words [$];
      int                 errors;

      function new();
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         thresh_reg = THRESHOLD_RESET;
         foreach (line_mem[i]) line_mem[i] = '0;
         left_pix   = '0;
         upleft_pix = '0;
         col_cnt    = 0;
         row_cnt    = 0;
         errors     = 0;
      endfunction

      function int unsigned fit_size(input logic [SIZE_W-1:0] v);
         if (v < 2) return 2;
         if (v > MAX_SIDE) return MAX_SIDE;
         return v;
      endfunction

      function int unsigned frame_pixels();
         return fit_size(width_reg) * fit_size(height_reg);
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
         case (idx)
            CSR_WIDTH: begin
               width_reg = data;
               col_cnt   = 0;
               row_cnt   = 0;
            end
            CSR_HEIGHT: begin
               height_reg = data;
               col_cnt    = 0;
               row_cnt    = 0;
            end
            CSR_THRESHOLD: thresh_reg = data[MAG_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned absdiff(input int unsigned a, input int unsigned b);
         return (a > b) ? a - b : b - a;
      endfunction

      function void push_word(input int unsigned c, input int unsigned r, input int unsigned m,
                              input bit last);
         edge_word_type w;
         w.col      = c[COORD_W-1:0];
         w.row      = r[COORD_W-1:0];
         w.mag      = m[MAG_W-1:0];
         w.edge_bit = (m[MAG_W-1:0] > thresh_reg);
         w.last     = last;
         due_words.push_back(w);
      endfunction

      // Queue every result word that this pixel completes, in emit order.
      function void take_pixel(input logic [PIXEL_W-1:0] px);
         int unsigned w, h, c, r, up, ul, lf, cur;
         w   = fit_size(width_reg);
         h   = fit_size(height_reg);
         c   = col_cnt;
         r   = row_cnt;
         if (c >= w) c = 0;
         if (r >= h) r = 0;
         cur = px;
         up  = line_mem[c % MAX_SIDE];
         ul  = upleft_pix;
         lf  = left_pix;
         if (r >= 1 && c >= 1) push_word(c - 1, r - 1, absdiff(ul, cur) + absdiff(up, lf), 1'b0);
         if (r >= 1 && c == w - 1) push_word(c, r - 1, up + cur, 1'b0);
         if (r == h - 1 && c >= 1) push_word(c - 1, r, lf + cur, 1'b0);
         if (r == h - 1 && c == w - 1) push_word(c, r, cur, 1'b1);
         line_mem[c % MAX_SIDE] = px;
         upleft_pix = up[PIXEL_W-1:0];
         left_pix   = px;
         c++;
         if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
         end
         col_cnt = c;
         row_cnt = r;
      endfunction

      task report(input string what, input logic [31:0] got, input logic [31:0] want);
         errors++;
         if (errors <= PRINT_CAP)
            $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
      endtask

      task match_word(input edge_word_type got);
         edge_word_type want;
         if (due_words.size() == 0) begin
            report("unexpected word, out_col", got.col, 0);
            return;
         end
         want = due_words.pop_front();
         if (got.col !== want.col) report("out_col", got.col, want.col);
         if (got.row !== want.row) report("out_row", got.row, want.row);
         if (got.mag !== want.mag) report("magnitude", got.mag, want.mag);
         if (got.edge_bit !== want.edge_bit) report("edge_bit", got.edge_bit, want.edge_bit);
         if (got.last !== want.last) report("frame_last", got.last, want.last);
      endtask

      function int pending();
         return due_words.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   bit          quiet = 1'b0;
   int          hold_req = 0;
   int          stall_cnt = 0;
   int          random_sent = 0;
   edge_checker sb = new();

   rce_req_if req_ch();
   rce_rsp_if rsp_ch();
   rce_csr_if csr_ch();

   roberts_cross_edge_threshold u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function bit lull();
      return !quiet && ($urandom_range(99) < IDLE_PCT);
   endfunction

   function logic [PIXEL_W-1:0] pick_pixel();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return PIXEL_W'($urandom_range(255));
      endcase
   endfunction

   // Reset the count whenever any word moves; give up after a long silence.
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
          (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)) begin
         stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
         $display("tb_roberts_cross_edge_threshold: errors");
         $finish;
      end else begin
         stall_cnt <= stall_cnt + 1;
      end
   end

   // Result side: random back-pressure plus an occasional long hold.
   initial begin
      int hold_left;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req != 0) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !lull();
         end
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.match_word({rsp_ch.out_col, rsp_ch.out_row, rsp_ch.magnitude,
                           rsp_ch.edge_bit, rsp_ch.frame_last});
      end
   end

   task automatic push_pixel(input logic [PIXEL_W-1:0] px);
      @(negedge clock);
      while (lull()) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pixel <= px;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.take_pixel(px);
   endtask

   task automatic send_pixels(input int unsigned n, input bit counted);
      for (int unsigned i = 0; i < n; i++) begin
         push_pixel(pick_pixel());
         if (counted) random_sent++;
      end
   endtask

   // Drop valid and hold until every due word is back and the pipe is empty.
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function logic [SIZE_W-1:0] pick_threshold();
      case ($urandom_range(5))
         0: return '0;
         1: return 11'd511;
         2: return SIZE_W'($urandom_range(2047));
         default: return SIZE_W'($urandom_range(300));
      endcase
   endfunction

   function logic [SIZE_W-1:0] pick_side(input int unsigned top);
      if ($urandom_range(7) == 0) return SIZE_W'($urandom_range(1));
      return SIZE_W'($urandom_range(top, 2));
   endfunction

   initial begin
      int unsigned phase;
      int unsigned frames;
      int unsigned burst;
      bit          partial;
      bit [2:0]    regs;

      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.pixel  = '0;
      csr_ch.valid  = 1'b0;
      csr_ch.index  = CSR_WIDTH;
      csr_ch.data   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset sizes: a few pixels of row 0, which complete nothing
      send_pixels(6, 1'b0);
      settle();

      // smallest frames, with out-of-range sizes clamped up to 2x2
      write_csr(CSR_WIDTH, 11'd1);
      write_csr(CSR_HEIGHT, 11'd0);
      write_csr(CSR_THRESHOLD, 11'd0);
      push_pixel(8'd0);   push_pixel(8'd0);   push_pixel(8'd0);   push_pixel(8'd0);
      push_pixel(8'd255); push_pixel(8'd0);   push_pixel(8'd255); push_pixel(8'd0);
      settle();
      write_csr(CSR_THRESHOLD, 11'h7FF);
      push_pixel(8'd255); push_pixel(8'd255); push_pixel(8'd255); push_pixel(8'd255);
      push_pixel(8'd0);   push_pixel(8'd255); push_pixel(8'd255); push_pixel(8'd0);
      settle();
      write_csr(CSR_THRESHOLD, 11'd254);
      write_csr(CSR_SPARE, 11'h5A5);
      push_pixel(8'd255); push_pixel(8'd255); push_pixel(8'd255); push_pixel(8'd255);
      settle();

      // long hold in phase 3 and the no-idle stretch in phase 5 always run
      phase = 0;
      while (phase <= 5 || random_sent < RANDOM_ITEMS) begin
         regs = 3'($urandom_range(7));
         if (phase == 1) regs = 3'b100;
         if (phase == 2) regs[0] = 1'b1;
         if (phase == 3 || phase == 5) regs = 3'b111;
         if (regs[0]) write_csr(CSR_WIDTH, (phase == 5) ? 11'd16 : pick_side(12));
         if (regs[1]) write_csr(CSR_HEIGHT, (phase == 5) ? 11'd5 : pick_side(6));
         if (regs[2]) write_csr(CSR_THRESHOLD, pick_threshold());
         if (phase == 3) begin
            write_csr(CSR_WIDTH, 11'd12);
            write_csr(CSR_HEIGHT, 11'd6);
            hold_req = 1;
         end
         quiet   = (phase == 5);
         frames  = (phase == 3 || phase == 5) ? 1 : $urandom_range(3, 1);
         partial = (phase < 2) ||
                   (phase != 3 && phase != 5 && $urandom_range(4) == 0);
         if (partial)
            burst = $urandom_range(sb.frame_pixels() * frames - 1, 1);
         else
            burst = sb.frame_pixels() * frames;
         if (phase != 3 && phase != 5 && burst > PHASE_CAP) burst = PHASE_CAP;
         send_pixels(burst, 1'b1);
         settle();
         quiet = 1'b0;
         phase++;
      end

      if (sb.errors == 0) begin
         $display("tb_roberts_cross_edge_threshold: clean");
      end else begin
         $display("tb_roberts_cross_edge_threshold: errors");
      end
      $finish;
   end
endmodule

>>> filelist.f
sv/rce_pkg.sv
sv/rce_if.sv
sv/rce_front.sv
sv/rce_queue.sv
sv/rce_back.sv
sv/roberts_cross_edge_threshold.sv
tb/tb_roberts_cross_edge_threshold.sv
